### src/sha_pkg.sv
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // request handed from the front queue to the core
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } core_req_t;

    // digest handed from the core to the result sender
    typedef struct packed {
        logic             load;
        logic [7:0][31:0] words;
    } digest_xfer_t;

    localparam logic OP_DATA     = 1'b0;
    localparam logic OP_FINALIZE = 1'b1;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    localparam logic [7:0][31:0] INIT_WORDS = {
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [63:0][31:0] ROUND_K = {
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // index 0 is the first hash word / first round constant
    function automatic logic [31:0] init_word(input logic [2:0] idx);
        return INIT_WORDS[3'd7 - idx];
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        return ROUND_K[6'd63 - idx];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

### src/sha_front.sv
`default_nettype none
module sha_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire sha_pkg::in_item_t item,
    output sha_pkg::core_req_t     req,
    input  wire logic              req_take
);
    import sha_pkg::*;

    in_item_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       wr_en;
    logic       rd_en;

    assign full      = (count_reg == 2'd2);
    assign wr_en     = push && !full;
    assign rd_en     = req_take && (count_reg != 2'd0);
    assign req.valid = (count_reg != 2'd0);
    assign req.item  = slot_reg[rd_ptr_reg];

    // hold incoming requests until the core takes them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= item;
    end

endmodule
`default_nettype wire

### src/sha_core.sv
`default_nettype none
module sha_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sha_pkg::core_req_t req,
    output logic                    req_take,
    input  wire logic               emit_busy,
    output sha_pkg::digest_xfer_t   digest
);
    import sha_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_SUM, S_EMIT} state_t;

    state_t            state_reg;
    logic [15:0][31:0] win_reg;
    logic [5:0]        fill_reg;
    logic [60:0]       total_reg;
    logic [63:0]       len_reg;
    logic              mark_reg;
    logic              wrap_reg;
    logic              lend_reg;
    logic              pad_reg;
    logic [5:0]        t_reg;
    logic [7:0][31:0]  hash_reg;
    logic [7:0][31:0]  v_reg;

    logic [519:0]      byte_shift;
    logic [7:0]        pad_byte;
    logic              pad_is_len;
    logic [7:0][31:0]  v_next;
    logic [31:0]       w_new;
    logic [31:0]       t1;
    logic [31:0]       t2;
    logic [31:0]       sig0;
    logic [31:0]       sig1;
    logic [31:0]       ch;
    logic [31:0]       maj;

    // choose the padding byte: mark, zeros, then length big-endian
    always_comb
    begin
        pad_is_len = mark_reg && (fill_reg >= LENGTH_POS) && !wrap_reg;
        priority if (!mark_reg)
            pad_byte = PAD_MARK;
        else if (pad_is_len)
            pad_byte = len_reg[63:56];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        byte_shift = {win_reg, (state_reg == S_PAD) ? pad_byte : req.item.data_byte};
    end

    // one compression round; v index 0 is a, 7 is h. win_reg[15] holds W(t)
    always_comb
    begin
        sig1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = v_reg[6] ^ (v_reg[4] & (v_reg[5] ^ v_reg[6]));
        t1   = v_reg[7] + sig1 + ch + round_k(t_reg) + win_reg[15];
        sig0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) | (v_reg[2] & (v_reg[0] ^ v_reg[1]));
        t2   = sig0 + maj;
        v_next[7] = v_reg[6];
        v_next[6] = v_reg[5];
        v_next[5] = v_reg[4];
        v_next[4] = v_reg[3] + t1;
        v_next[3] = v_reg[2];
        v_next[2] = v_reg[1];
        v_next[1] = v_reg[0];
        v_next[0] = t1 + t2;
        w_new = (rotr(win_reg[1], 17) ^ rotr(win_reg[1], 19) ^ (win_reg[1] >> 10))
              + win_reg[6]
              + (rotr(win_reg[14], 7) ^ rotr(win_reg[14], 18) ^ (win_reg[14] >> 3))
              + win_reg[15];
    end

    assign req_take     = (state_reg == S_IDLE);
    assign digest.load  = (state_reg == S_EMIT) && !emit_busy;
    assign digest.words = hash_reg;

    // sequence absorb, padding, rounds, hash update and digest handoff
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            total_reg <= '0;
            mark_reg  <= 1'b0;
            wrap_reg  <= 1'b0;
            lend_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            t_reg     <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_word(3'(i));
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.item.opcode == OP_DATA)
                        begin
                            win_reg   <= byte_shift[511:0];
                            fill_reg  <= fill_reg + 6'd1;
                            total_reg <= total_reg + 61'd1;
                            if (fill_reg == 6'd63)
                            begin
                                v_reg     <= hash_reg;
                                t_reg     <= '0;
                                state_reg <= S_ROUND;
                            end
                        end
                        else
                        begin
                            len_reg   <= {total_reg, 3'b000};
                            pad_reg   <= 1'b1;
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    win_reg  <= byte_shift[511:0];
                    fill_reg <= fill_reg + 6'd1;
                    if (!mark_reg)
                    begin
                        mark_reg <= 1'b1;
                    end
                    else if (pad_is_len)
                    begin
                        len_reg <= {len_reg[55:0], 8'h00};
                        if (fill_reg == 6'd63)
                            lend_reg <= 1'b1;
                    end
                    if (fill_reg == 6'd63)
                    begin
                        wrap_reg  <= 1'b0;
                        v_reg     <= hash_reg;
                        t_reg     <= '0;
                        state_reg <= S_ROUND;
                    end
                    else if (!mark_reg)
                        wrap_reg <= (fill_reg >= LENGTH_POS);
                end
                S_ROUND:
                begin
                    v_reg   <= v_next;
                    win_reg <= {win_reg[14:0], w_new};
                    t_reg   <= t_reg + 6'd1;
                    if (t_reg == 6'd63)
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    priority if (lend_reg)
                        state_reg <= S_EMIT;
                    else if (pad_reg)
                        state_reg <= S_PAD;
                    else
                        state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (!emit_busy)
                    begin
                        for (int i = 0; i < 8; i++)
                            hash_reg[i] <= init_word(3'(i));
                        fill_reg  <= '0;
                        total_reg <= '0;
                        mark_reg  <= 1'b0;
                        wrap_reg  <= 1'b0;
                        lend_reg  <= 1'b0;
                        pad_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### src/sha_emit.sv
`default_nettype none
module sha_emit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sha_pkg::digest_xfer_t digest,
    output logic                      busy,
    output logic                      empty,
    input  wire logic                 pop,
    output sha_pkg::out_item_t        result
);
    import sha_pkg::*;

    logic [31:0] word_reg [8];
    logic [2:0]  idx_reg;
    logic        busy_reg;

    assign busy               = busy_reg;
    assign empty              = !busy_reg;
    assign result.digest_word = word_reg[idx_reg];
    assign result.word_index  = idx_reg;
    assign result.last_word   = (idx_reg == 3'd7);

    // step through the eight words, release when the last is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (digest.load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (pop && busy_reg)
        begin
            idx_reg <= idx_reg + 3'd1;
            if (idx_reg == 3'd7)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (digest.load)
            for (int i = 0; i < 8; i++)
                word_reg[i] <= digest.words[3'(i)];
    end

endmodule
`default_nettype wire

### src/sha256_stream_hasher.sv
`default_nettype none
// The core absorbs a data request while idle; every 64th byte adds a compression
// (64 rounds at one round per cycle, one hash update) in which no request is taken.
// A finalize request emits padding one byte per cycle plus one or two compressions;
// then the digest goes to the sender once it is free; one word leaves per pop.
// A two-entry request queue keeps accepting while the core works, until it is full.
// Reset (rst_n low, asynchronous) empties both queues and restores the initial hash.
module sha256_stream_hasher (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire sha_pkg::in_item_t item,
    output logic                   empty,
    input  wire logic              pop,
    output sha_pkg::out_item_t     result
);
    import sha_pkg::*;

    core_req_t    req;
    logic         req_take;
    logic         emit_busy;
    digest_xfer_t digest;

    sha_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .req      (req),
        .req_take (req_take)
    );

    sha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_take  (req_take),
        .emit_busy (emit_busy),
        .digest    (digest)
    );

    sha_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .digest (digest),
        .busy   (emit_busy),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire

### src/sha_checker.sv
`default_nettype none
module sha_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire sha_pkg::out_item_t result
);
    import sha_pkg::*;

    // the last word always sits at the final digest position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last_word) |-> (result.word_index == 3'd7))
        else $error("last word not at index 7");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result changed");

    // words of one digest follow in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last_word) |=>
        (!empty && result.word_index == $past(result.word_index) + 3'd1))
        else $error("digest words out of order");

    // a finished digest leaves a gap before the next one
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.last_word) |=> empty)
        else $error("no gap after last word");

endmodule

bind sha256_stream_hasher sha_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
`default_nettype wire
